FILE: rtl/scsa_pkg.sv
// shared types, constants and helpers for the size class slab allocator
// no dependencies
package scsa_pkg;

    localparam int PAGE_COUNT      = 16;
    localparam int BLOCKS_PER_PAGE = 1024;
    localparam int NUM_CLASSES     = 28;
    localparam int MAX_SMALL       = 512;

    localparam int PW   = $clog2(PAGE_COUNT);
    localparam int BW   = $clog2(BLOCKS_PER_PAGE);
    localparam int CW   = 5;
    localparam int AW   = PW + BW;
    localparam int IW   = BW + 1;
    localparam int LW   = PW + 1;

    localparam logic [IW-1:0] IDX_NIL  = {1'b1, {BW{1'b0}}};
    localparam logic [LW-1:0] PAGE_NIL = {1'b1, {PW{1'b0}}};

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_PAGE   = 2'd1,
        STAT_NOT_SMALL = 2'd2,
        STAT_BAD_FREE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic latch;
        logic lookup;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
    } stat_t;

    // blocks per page for each class, capped at the page block count
    localparam logic [IW-1:0] BLOCKS_OF_CLASS [NUM_CLASSES] = '{
        11'd1019, 11'd679, 11'd509, 11'd407, 11'd339, 11'd291, 11'd254,
        11'd226, 11'd185, 11'd156, 11'd135, 11'd119, 11'd107, 11'd97,
        11'd88, 11'd81, 11'd75, 11'd70, 11'd65,
        11'd61, 11'd55, 11'd49, 11'd45, 11'd41, 11'd38, 11'd35, 11'd33, 11'd31
    };

    function automatic logic is_small(input logic [15:0] s);
        return (s != 16'd0) && (s <= 16'(MAX_SMALL));
    endfunction

    function automatic logic [CW-1:0] class_of(input logic [15:0] s);
        logic [15:0] t;
        t = 16'd0;
        if (s <= 16'd56)
            t = (s - 16'd1) >> 3;
        else if (s <= 16'd240)
            t = 16'd7 + ((s - 16'd49) >> 4);
        else
            t = 16'd19 + ((s - 16'd225) >> 5);
        return t[CW-1:0];
    endfunction

endpackage

FILE: rtl/scsa_ctrl.sv
// request sequencer: accept, table lookup with block memory read, commit
// depends on scsa_pkg
module scsa_ctrl
    import scsa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  stat_t  stat,
    output cmd_t   cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_LOOK;
            end
            S_LOOK:
                state_next = S_COMMIT;
            S_COMMIT:
            begin
                if (stat.slot_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        cmd.latch  = (state_reg == S_IDLE) && in_valid;
        cmd.lookup = (state_reg == S_LOOK);
        cmd.commit = (state_reg == S_COMMIT) && stat.slot_free;
    end

endmodule

FILE: rtl/scsa_datapath.sv
// page tables, class lists, block link memory and result register
// depends on scsa_pkg
module scsa_datapath
    import scsa_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  cmd_t           cmd,
    output stat_t          stat,
    input  logic           kind,
    input  logic [15:0]    request_size,
    input  logic [AW-1:0]  block_address,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     status,
    output logic [AW-1:0]  granted_address,
    output logic [CW-1:0]  chosen_class,
    output logic           page_released,
    output logic [31:0]    bytes_in_use
);

    // request
    logic           kind_reg;
    logic [15:0]    size_reg;
    logic [AW-1:0]  addr_reg;

    // lookup results
    logic [CW-1:0]  c_reg;
    logic           small_reg;
    logic [PW-1:0]  p_reg;
    logic           new_reg;
    logic           nopage_reg;
    logic           badpre_reg;

    // tables
    logic [PW-1:0]  lh_reg      [NUM_CLASSES];
    logic           lh_valid_reg[NUM_CLASSES];
    logic           busy_reg    [PAGE_COUNT];
    logic [CW-1:0]  pclass_reg  [PAGE_COUNT];
    logic [IW-1:0]  bump_reg    [PAGE_COUNT];
    logic [IW-1:0]  used_reg    [PAGE_COUNT];
    logic [IW-1:0]  fhead_reg   [PAGE_COUNT];
    logic [LW-1:0]  prev_reg    [PAGE_COUNT];
    logic [LW-1:0]  next_reg    [PAGE_COUNT];

    // block memory: in-use bit and free link
    logic [IW:0]    blk_mem [PAGE_COUNT * BLOCKS_PER_PAGE];
    logic [IW:0]    mem_q_reg;

    logic [31:0]    total_reg;
    logic           out_valid_reg;
    logic [1:0]     status_reg;
    logic [AW-1:0]  granted_reg;
    logic [CW-1:0]  class_out_reg;
    logic           released_reg;

    // lookup stage
    logic [CW-1:0]  lk_c;
    logic           lk_small;
    logic [PW-1:0]  lk_fp;
    logic           lk_any_free;
    logic [PW-1:0]  lk_p;
    logic [BW-1:0]  lk_rd_idx;

    always_comb
    begin
        lk_small    = is_small(size_reg);
        lk_c        = lk_small ? class_of(size_reg) : '0;
        lk_fp       = '0;
        lk_any_free = 1'b0;
        for (int i = PAGE_COUNT - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                lk_fp       = PW'(i);
                lk_any_free = 1'b1;
            end
        end
        if (kind_reg)
            lk_p = addr_reg[AW-1:BW];
        else if (lh_valid_reg[lk_c])
            lk_p = lh_reg[lk_c];
        else
            lk_p = lk_fp;
        lk_rd_idx = kind_reg ? addr_reg[BW-1:0] : fhead_reg[lk_p][BW-1:0];
    end

    // commit stage
    logic [BW-1:0]  f_idx;
    logic [IW-1:0]  e_bump, e_head, e_used, n_bump, n_head;
    logic [LW-1:0]  e_pv, e_nx, h_ref, pv1, nx1;
    logic           e_lhv, lh1v, hv;
    logic [PW-1:0]  e_lh, lh1, hp;
    logic [BW-1:0]  a_idx;
    logic [IW-1:0]  bump_m1;
    logic           a_unlink, a_ok, f_ok, wasfull, f_release;
    logic [IW-1:0]  n_used;
    logic [AW-1:0]  mem_wa;

    always_comb
    begin
        f_idx   = addr_reg[BW-1:0];
        hv      = lh_valid_reg[c_reg];
        hp      = lh_reg[c_reg];
        h_ref   = {~hv, hp};
        e_bump  = new_reg ? BLOCKS_OF_CLASS[c_reg] : bump_reg[p_reg];
        e_head  = new_reg ? IDX_NIL : fhead_reg[p_reg];
        e_used  = new_reg ? '0 : used_reg[p_reg];
        e_pv    = new_reg ? PAGE_NIL : prev_reg[p_reg];
        e_nx    = new_reg ? PAGE_NIL : next_reg[p_reg];
        e_lhv   = new_reg ? 1'b1 : hv;
        e_lh    = new_reg ? p_reg : hp;
        bump_m1 = e_bump - IW'(1);
        if (e_bump != '0)
        begin
            a_idx  = bump_m1[BW-1:0];
            n_bump = bump_m1;
            n_head = e_head;
        end
        else
        begin
            a_idx  = e_head[BW-1:0];
            n_bump = '0;
            n_head = mem_q_reg[IW-1:0];
        end
        a_unlink  = (n_bump == '0) && n_head[IW-1];
        a_ok      = small_reg && !kind_reg && !nopage_reg;

        f_ok      = small_reg && kind_reg && !badpre_reg && mem_q_reg[IW]
                    && ({1'b0, f_idx} >= bump_reg[p_reg]);
        wasfull   = (bump_reg[p_reg] == '0) && fhead_reg[p_reg][IW-1];
        n_used    = used_reg[p_reg] - IW'(1);
        f_release = (n_used == '0);
        pv1       = wasfull ? PAGE_NIL : prev_reg[p_reg];
        nx1       = wasfull ? h_ref : next_reg[p_reg];
        lh1v      = wasfull ? 1'b1 : hv;
        lh1       = wasfull ? p_reg : hp;

        mem_wa    = kind_reg ? {p_reg, f_idx} : {p_reg, a_idx};
    end

    // input latch and lookup
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg <= kind;
            size_reg <= request_size;
            addr_reg <= block_address;
        end
        if (cmd.lookup)
        begin
            c_reg      <= lk_c;
            small_reg  <= lk_small;
            p_reg      <= lk_p;
            new_reg    <= !lh_valid_reg[lk_c];
            nopage_reg <= !lh_valid_reg[lk_c] && !lk_any_free;
            badpre_reg <= !busy_reg[lk_p] || (pclass_reg[lk_p] != lk_c)
                          || ({1'b0, addr_reg[BW-1:0]} >= BLOCKS_OF_CLASS[lk_c]);
            mem_q_reg  <= blk_mem[{lk_p, lk_rd_idx}];
        end
    end

    // block memory write
    always_ff @(posedge clk)
    begin
        if (cmd.commit && (a_ok || f_ok))
            blk_mem[mem_wa] <= a_ok ? {1'b1, mem_q_reg[IW-1:0]} : {1'b0, fhead_reg[p_reg]};
    end

    // page tables without reset
    always_ff @(posedge clk)
    begin
        if (cmd.commit && a_ok)
        begin
            pclass_reg[p_reg] <= c_reg;
            bump_reg[p_reg]   <= n_bump;
            fhead_reg[p_reg]  <= n_head;
            used_reg[p_reg]   <= e_used + IW'(1);
            prev_reg[p_reg]   <= e_pv;
            next_reg[p_reg]   <= e_nx;
            if (a_unlink)
            begin
                if (!e_nx[PW])
                    prev_reg[e_nx[PW-1:0]] <= e_pv;
                if (!e_pv[PW])
                    next_reg[e_pv[PW-1:0]] <= e_nx;
                prev_reg[p_reg] <= PAGE_NIL;
                next_reg[p_reg] <= PAGE_NIL;
            end
        end
        if (cmd.commit && f_ok)
        begin
            if (wasfull)
            begin
                next_reg[p_reg] <= h_ref;
                prev_reg[p_reg] <= PAGE_NIL;
                if (hv)
                    prev_reg[hp] <= {1'b0, p_reg};
            end
            fhead_reg[p_reg] <= {1'b0, f_idx};
            used_reg[p_reg]  <= n_used;
            if (f_release)
            begin
                if (!nx1[PW])
                    prev_reg[nx1[PW-1:0]] <= pv1;
                if (!pv1[PW])
                    next_reg[pv1[PW-1:0]] <= nx1;
                prev_reg[p_reg] <= PAGE_NIL;
                next_reg[p_reg] <= PAGE_NIL;
            end
        end
    end

    // class lists, busy bits, byte total and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                lh_reg[i]       <= '0;
                lh_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < PAGE_COUNT; i++)
                busy_reg[i] <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= STAT_OK;
            granted_reg   <= '0;
            class_out_reg <= '0;
            released_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                granted_reg   <= '0;
                released_reg  <= 1'b0;
                class_out_reg <= small_reg ? c_reg : '0;
                if (!small_reg)
                begin
                    status_reg <= STAT_NOT_SMALL;
                    total_reg  <= kind_reg ? total_reg - {16'd0, size_reg}
                                           : total_reg + {16'd0, size_reg};
                end
                else if (!kind_reg)
                begin
                    if (nopage_reg)
                        status_reg <= STAT_NO_PAGE;
                    else
                    begin
                        status_reg     <= STAT_OK;
                        granted_reg    <= {p_reg, a_idx};
                        total_reg      <= total_reg + {16'd0, size_reg};
                        busy_reg[p_reg] <= 1'b1;
                        if (new_reg)
                        begin
                            lh_reg[c_reg]       <= p_reg;
                            lh_valid_reg[c_reg] <= 1'b1;
                        end
                        if (a_unlink && e_pv[PW] && e_lhv && (e_lh == p_reg))
                        begin
                            lh_reg[c_reg]       <= e_nx[PW-1:0];
                            lh_valid_reg[c_reg] <= !e_nx[PW];
                        end
                    end
                end
                else if (!f_ok)
                    status_reg <= STAT_BAD_FREE;
                else
                begin
                    status_reg <= STAT_OK;
                    total_reg  <= total_reg - {16'd0, size_reg};
                    if (wasfull)
                    begin
                        lh_reg[c_reg]       <= p_reg;
                        lh_valid_reg[c_reg] <= 1'b1;
                    end
                    if (f_release)
                    begin
                        busy_reg[p_reg] <= 1'b0;
                        released_reg    <= 1'b1;
                        if (pv1[PW] && lh1v && (lh1 == p_reg))
                        begin
                            lh_reg[c_reg]       <= nx1[PW-1:0];
                            lh_valid_reg[c_reg] <= !nx1[PW];
                        end
                    end
                end
            end
        end
    end

    assign stat.slot_free   = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign granted_address  = granted_reg;
    assign chosen_class     = class_out_reg;
    assign page_released    = released_reg;
    assign bytes_in_use     = total_reg;

endmodule

FILE: rtl/size_class_slab_allocator_core.sv
// Slab allocator with 28 size classes over 16 pages of up to 1024 blocks.
// After a request is taken, a lookup state reads the class list, page tables
// and block link memory, and a commit state then updates tables and memory and
// loads the result into the output register. A new request is taken in the
// cycle after the update; the block takes no new request while one is in
// progress. A result that waits to be taken holds only the update of the next
// request. No clearing pass is needed after reset.
// depends on scsa_pkg, scsa_ctrl, scsa_datapath
module size_class_slab_allocator_core
    import scsa_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           kind,
    input  logic [15:0]    request_size,
    input  logic [AW-1:0]  block_address,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     status,
    output logic [AW-1:0]  granted_address,
    output logic [CW-1:0]  chosen_class,
    output logic           page_released,
    output logic [31:0]    bytes_in_use
);

    cmd_t  cmd;
    stat_t stat;

    scsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scsa_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .kind            (kind),
        .request_size    (request_size),
        .block_address   (block_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .granted_address (granted_address),
        .chosen_class    (chosen_class),
        .page_released   (page_released),
        .bytes_in_use    (bytes_in_use)
    );

`ifndef ASSERT_OFF
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one in progress");

    a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STAT_OK) |-> (granted_address == '0))
        else $error("address granted on failed request");

    a_release_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && page_released |-> (status == STAT_OK))
        else $error("page released on failed request");

    a_not_small_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_NOT_SMALL) |-> (chosen_class == '0))
        else $error("class reported for size that is not small");
`endif

endmodule
